// ----- src/tea_block_cipher_macros.svh -----
// assertion macros shared by the cipher rtl
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

// checked only while out of reset
`define TEA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TEA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tea_pkg.sv -----
// types, constants and helpers for the tea cipher pipeline
`default_nettype none

package tea_pkg;

	localparam int unsigned ROUNDS_DEFAULT = 32;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_0 = 2'd0,
		REG_KEY_1 = 2'd1,
		REG_KEY_2 = 2'd2,
		REG_KEY_3 = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] k3;
		logic [WORD_W-1:0] k2;
		logic [WORD_W-1:0] k1;
		logic [WORD_W-1:0] k0;
	} key_t;

	// delta times n, wrapped to 32 bits
	function automatic logic [WORD_W-1:0] delta_times(input int unsigned n);
		logic [63:0] p;
		p = 64'(DELTA) * 64'(n);
		return p[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/tea_half_round.sv -----
// one half round of tea: mix one word into the other, forward or backward
`default_nettype none

module tea_half_round #(
	parameter bit                             SECOND  = 1'b0,
	parameter logic [tea_pkg::WORD_W-1:0]     SUM_ENC = '0,
	parameter logic [tea_pkg::WORD_W-1:0]     SUM_DEC = '0
) (
	input  tea_pkg::op_t                  op,
	input  tea_pkg::key_t                 key,
	input  logic [tea_pkg::WORD_W-1:0]    word_0,
	input  logic [tea_pkg::WORD_W-1:0]    word_1,
	output logic [tea_pkg::WORD_W-1:0]    word_0_nxt,
	output logic [tea_pkg::WORD_W-1:0]    word_1_nxt
);

	logic                          enc;
	logic                          upd_0;
	logic [tea_pkg::WORD_W-1:0]    src;
	logic [tea_pkg::WORD_W-1:0]    tgt;
	logic [tea_pkg::WORD_W-1:0]    ka;
	logic [tea_pkg::WORD_W-1:0]    kb;
	logic [tea_pkg::WORD_W-1:0]    sum;
	logic [tea_pkg::WORD_W-1:0]    mix;
	logic [tea_pkg::WORD_W-1:0]    res;

	// encrypt updates word 0 first, decrypt updates word 1 first
	assign enc   = (op == tea_pkg::OP_ENCRYPT);
	assign upd_0 = enc ^ SECOND;
	assign src   = upd_0 ? word_1 : word_0;
	assign tgt   = upd_0 ? word_0 : word_1;
	assign ka    = upd_0 ? key.k0 : key.k2;
	assign kb    = upd_0 ? key.k1 : key.k3;
	assign sum   = enc ? SUM_ENC : SUM_DEC;

	assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
	assign res = enc ? (tgt + mix) : (tgt - mix);

	assign word_0_nxt = upd_0 ? res : word_0;
	assign word_1_nxt = upd_0 ? word_1 : res;

endmodule

`default_nettype wire

// ----- src/tea_block_cipher.sv -----
// tea block cipher, one half round per pipeline stage, with output skid buffer
//
//  channel | dir | handshake                      | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata {word_1, word_0}, tuser op
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata {out_word_1, out_word_0}
//  cfg     | in  | cfg_we                         | cfg_index, cfg_data (key words 0..3)
//
// one block accepted per cycle while s_axis_tready is high; one register stage per
// half round (add, xor, add deep) plus the output register
// reset clears the valid bits, the output and skid valid flags, and the four key words
// a stalled output fills the skid register; only then does s_axis_tready drop
// and the whole pipeline hold, so nothing is lost or repeated
`default_nettype none
`include "tea_block_cipher_macros.svh"

module tea_block_cipher #(
	parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [tea_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tea_pkg::WORD_W-1:0]         cfg_data,
	// input blocks
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [2*tea_pkg::WORD_W-1:0]       s_axis_tdata,  // word_0, word_1
	input  logic                               s_axis_tuser,  // op
	// result blocks
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [2*tea_pkg::WORD_W-1:0]       m_axis_tdata   // out_word_0, out_word_1
);

	localparam int unsigned NSTAGE = 2 * ROUNDS;
	localparam int unsigned W      = tea_pkg::WORD_W;

	// key registers
	tea_pkg::key_t key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (tea_pkg::cfg_reg_t'(cfg_index))
				tea_pkg::REG_KEY_0: key_q.k0 <= cfg_data;
				tea_pkg::REG_KEY_1: key_q.k1 <= cfg_data;
				tea_pkg::REG_KEY_2: key_q.k2 <= cfg_data;
				tea_pkg::REG_KEY_3: key_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless the skid register is occupied
	logic pipe_en;
	logic skid_valid_q;
	logic out_valid_q;
	logic [2*W-1:0] out_data_q;
	logic [2*W-1:0] skid_data_q;

	assign pipe_en       = !skid_valid_q;
	assign s_axis_tready = pipe_en;

	// stage registers, index = number of half rounds done
	logic              valid_s [1:NSTAGE];
	tea_pkg::op_t      op_s    [1:NSTAGE];
	logic [W-1:0]      w0_s    [1:NSTAGE];
	logic [W-1:0]      w1_s    [1:NSTAGE];

	for (genvar i = 1; i <= NSTAGE; i++) begin : g_stage
		localparam int unsigned RND    = (i - 1) / 2;
		localparam bit          SECOND = ((i - 1) % 2) == 1;
		localparam logic [W-1:0] SUM_ENC = tea_pkg::delta_times(RND + 1);
		localparam logic [W-1:0] SUM_DEC = tea_pkg::delta_times(ROUNDS - RND);

		logic         in_valid;
		tea_pkg::op_t in_op;
		logic [W-1:0] in_w0;
		logic [W-1:0] in_w1;
		logic [W-1:0] nxt_w0;
		logic [W-1:0] nxt_w1;

		if (i == 1) begin : g_src_port
			assign in_valid = s_axis_tvalid;
			assign in_op    = tea_pkg::op_t'(s_axis_tuser);
			assign in_w0    = s_axis_tdata[W-1:0];
			assign in_w1    = s_axis_tdata[2*W-1:W];
		end else begin : g_src_stage
			assign in_valid = valid_s[i-1];
			assign in_op    = op_s[i-1];
			assign in_w0    = w0_s[i-1];
			assign in_w1    = w1_s[i-1];
		end

		tea_half_round #(
			.SECOND  (SECOND),
			.SUM_ENC (SUM_ENC),
			.SUM_DEC (SUM_DEC)
		) u_half (
			.op         (in_op),
			.key        (key_q),
			.word_0     (in_w0),
			.word_1     (in_w1),
			.word_0_nxt (nxt_w0),
			.word_1_nxt (nxt_w1)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (pipe_en) begin
				valid_s[i] <= in_valid;
			end
		end

		// payload carries no reset
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				op_s[i] <= in_op;
				w0_s[i] <= nxt_w0;
				w1_s[i] <= nxt_w1;
			end
		end
	end

	// output register plus one skid entry
	logic           push;
	logic           pop;
	logic [2*W-1:0] last_data;

	assign push      = pipe_en && valid_s[NSTAGE];
	assign pop       = out_valid_q && m_axis_tready;
	assign last_data = {w1_s[NSTAGE], w0_s[NSTAGE]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_data_q <= last_data;
			end else begin
				skid_data_q <= last_data;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// the skid entry is only ever used behind a full output register
	`TEA_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
	// the skid entry fills only when the output was stalled
	`TEA_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready), "skid filled without stall")
	// while the skid entry is held the last stage must not move
	`TEA_ASSERT(a_pipe_holds, skid_valid_q |=> $stable(valid_s[NSTAGE]), "pipeline moved during stall")
	// reset empties the output side by the following edge
	`TEA_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!out_valid_q && !skid_valid_q), "output valid in reset")

endmodule

`default_nettype wire

// ----- tb/tb_tea_block_cipher.sv -----
// self-checking testbench for the tea block cipher: directed vectors, then random traffic
`default_nettype none

module tb_tea_block_cipher;
	import tea_pkg::*;

	localparam int unsigned NUM_ROUNDS = ROUNDS_DEFAULT;
	localparam int unsigned PIPE_LATENCY = 2 * NUM_ROUNDS + 1;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned ITEMS_PER_PHASE = 125;
	localparam int unsigned NUM_VECTORS = 12;

	typedef struct packed {
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w0;
	} tea_block_t;

	// one directed vector; the typed result only holds under the all-zero key
	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic              typed;
		logic [WORD_W-1:0] e0;
		logic [WORD_W-1:0] e1;
	} vector_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_INDEX_W-1:0]   cfg_index;
	logic [WORD_W-1:0]        cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [2*WORD_W-1:0]      s_axis_tdata;  // word_0, word_1
	logic                     s_axis_tuser;  // op
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [2*WORD_W-1:0]      m_axis_tdata;  // out_word_0, out_word_1

	key_t                     cipher_key;
	tea_block_t               expected_blocks[$];
	int unsigned              error_count;
	int unsigned              quiet_cycles;
	int unsigned              send_idle_pct;
	int unsigned              recv_stall_pct;

	vector_row_t vectors [NUM_VECTORS] = '{
		'{OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b1, 32'h41ea3a0a, 32'h94baa940},
		'{OP_DECRYPT, 32'h41ea3a0a, 32'h94baa940, 1'b1, 32'h00000000, 32'h00000000},
		'{OP_ENCRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
		'{OP_DECRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
		'{OP_ENCRYPT, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 32'h0},
		'{OP_DECRYPT, 32'hffffffff, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{OP_ENCRYPT, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0, 32'h0},
		'{OP_DECRYPT, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0, 32'h0},
		'{OP_ENCRYPT, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
		'{OP_DECRYPT, 32'h00000001, 32'h80000000, 1'b0, 32'h0, 32'h0},
		'{OP_ENCRYPT, 32'h01234567, 32'h89abcdef, 1'b0, 32'h0, 32'h0},
		'{OP_DECRYPT, 32'h89abcdef, 32'h01234567, 1'b0, 32'h0, 32'h0}
	};

	tea_block_cipher u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one half-round mixing term
	function automatic logic [WORD_W-1:0] mix_term(logic [WORD_W-1:0] h, logic [WORD_W-1:0] s,
			logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
		return ((h << 4) + ka) ^ (h + s) ^ ((h >> 5) + kb);
	endfunction

	// full tea pass under the current key, all sums wrap at 32 bits
	function automatic tea_block_t tea_cipher(op_t op, logic [WORD_W-1:0] w0,
			logic [WORD_W-1:0] w1);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] sum;
		tea_block_t res;
		a = w0;
		b = w1;
		if (op == OP_ENCRYPT) begin
			sum = '0;
			for (int r = 0; r < NUM_ROUNDS; r++) begin
				sum = sum + DELTA;
				a = a + mix_term(b, sum, cipher_key.k0, cipher_key.k1);
				b = b + mix_term(a, sum, cipher_key.k2, cipher_key.k3);
			end
		end else begin
			sum = '0;
			for (int r = 0; r < NUM_ROUNDS; r++)
				sum = sum + DELTA;
			for (int r = 0; r < NUM_ROUNDS; r++) begin
				b = b - mix_term(a, sum, cipher_key.k2, cipher_key.k3);
				a = a - mix_term(b, sum, cipher_key.k0, cipher_key.k1);
				sum = sum - DELTA;
			end
		end
		res.w0 = a;
		res.w1 = b;
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_KEY_0: cipher_key.k0 = val;
			REG_KEY_1: cipher_key.k1 = val;
			REG_KEY_2: cipher_key.k2 = val;
			REG_KEY_3: cipher_key.k3 = val;
		endcase
	endtask

	task automatic load_key(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1,
			logic [WORD_W-1:0] k2, logic [WORD_W-1:0] k3);
		write_reg(REG_KEY_0, k0);
		write_reg(REG_KEY_1, k1);
		write_reg(REG_KEY_2, k2);
		write_reg(REG_KEY_3, k3);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// always advances at least one edge so a following drive lands in a new step
	task automatic wait_drained();
		do
			@(posedge clk);
		while (expected_blocks.size() != 0);
	endtask

	// leaves tvalid high after the transaction; the next call lowers it only for a gap
	task automatic send_block(op_t op, logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
			tea_block_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {w1, w0};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_blocks.push_back(want);
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// receiver backpressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker and watchdog
	always @(posedge clk) begin
		tea_block_t want;
		tea_block_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", got));
				end else begin
					want = expected_blocks.pop_front();
					if (got.w0 !== want.w0)
						report_mismatch($sformatf("out_word_0 %h, want %h", got.w0, want.w0));
					if (got.w1 !== want.w1)
						report_mismatch($sformatf("out_word_1 %h, want %h", got.w1, want.w1));
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("tb_tea_block_cipher NOT OK");
				$finish;
			end
		end
	end

	initial begin
		tea_block_t want;
		tea_block_t last_out;
		op_t op;
		op_t last_op;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ENCRYPT;
		m_axis_tready = 1'b1;
		cipher_key = '0;
		error_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		last_out = '0;
		last_op = OP_ENCRYPT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed vectors: first under the reset key, then under the all-ones key
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
				load_key('1, '1, '1, '1);
			end
			for (int i = 0; i < NUM_VECTORS; i++) begin
				if (pass == 0 && vectors[i].typed)
					want = {vectors[i].e1, vectors[i].e0};
				else
					want = tea_cipher(vectors[i].op, vectors[i].w0, vectors[i].w1);
				send_block(vectors[i].op, vectors[i].w0, vectors[i].w1, want);
			end
		end

		// random traffic, one key and one idling pattern per phase
		for (int phase = 0; phase < 4; phase++) begin
			s_axis_tvalid <= 1'b0;
			wait_drained();
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			if (phase == 0)
				load_key('0, '1, '0, '1);
			else
				load_key($urandom, $urandom, $urandom, $urandom);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// now and then feed the last result back with the opposite operation
				if (n > 0 && $urandom_range(3) == 0) begin
					op = (last_op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
					w0 = last_out.w0;
					w1 = last_out.w1;
				end else begin
					op = op_t'($urandom_range(1));
					w0 = random_word();
					w1 = random_word();
				end
				want = tea_cipher(op, w0, w1);
				send_block(op, w0, w1, want);
				last_op = op;
				last_out = want;
				// hold off the sender until the pipeline has fully drained
				if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
					s_axis_tvalid <= 1'b0;
					wait_drained();
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (expected_blocks.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_blocks.size()));
		if (error_count == 0) begin
			$display("tb_tea_block_cipher OK");
		end else begin
			$display("tb_tea_block_cipher NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
